@@ rtl/dci_pkg.sv @@
// Package for the drive command interlock.
// Holds the field widths, code types, constants and the command decoder.
// No dependencies.
package dci_pkg;

    localparam int DIST_W  = 9;
    localparam int AGE_W   = 5;
    localparam int SPEED_W = 7;
    localparam int SEQ_W   = 16;
    localparam int CFG_W   = 9;

    localparam logic [DIST_W-1:0]  NO_ECHO_CM      = 9'd400;
    localparam logic [DIST_W-1:0]  STOP_DIST_RESET = 9'd20;
    localparam logic [AGE_W-1:0]   TIMEOUT_RESET   = 5'd20;
    localparam logic [SPEED_W-1:0] SPEED_MAX       = 7'd100;
    localparam logic [SPEED_W-1:0] SPEED_INC_LIMIT = 7'd90;
    localparam logic [SPEED_W-1:0] SPEED_STEP      = 7'd10;
    localparam logic [SPEED_W-1:0] SPEED_RESET     = 7'd50;

    typedef enum logic {
        OP_TICK   = 1'b0,
        OP_SAMPLE = 1'b1
    } op_t;

    typedef enum logic {
        MODE_MANUAL = 1'b0,
        MODE_AUTO   = 1'b1
    } mode_t;

    typedef enum logic {
        REG_STOP_DIST = 1'b0,
        REG_TIMEOUT   = 1'b1
    } reg_index_t;

    typedef enum logic [2:0] {
        ACT_STOP  = 3'd0,
        ACT_FWD   = 3'd1,
        ACT_BACK  = 3'd2,
        ACT_LEFT  = 3'd3,
        ACT_RIGHT = 3'd4
    } action_t;

    typedef enum logic [3:0] {
        CMD_F       = 4'd0,
        CMD_M       = 4'd1,
        CMD_W       = 4'd2,
        CMD_S       = 4'd3,
        CMD_A       = 4'd4,
        CMD_D       = 4'd5,
        CMD_Q       = 4'd6,
        CMD_E       = 4'd7,
        CMD_P       = 4'd8,
        CMD_PLUS    = 4'd9,
        CMD_MINUS   = 4'd10,
        CMD_UNKNOWN = 4'd11
    } cmd_t;

    typedef enum logic [1:0] {
        ST_EXECUTED = 2'd0,
        ST_BLOCKED  = 2'd1,
        ST_REJECTED = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        RSN_NONE     = 2'd0,
        RSN_OBSTACLE = 2'd1,
        RSN_UNKNOWN  = 2'd2
    } reason_t;

    typedef enum logic [2:0] {
        BUZ_NONE    = 3'd0,
        BUZ_STARTUP = 3'd1,
        BUZ_MODE    = 3'd2,
        BUZ_REVERSE = 3'd3,
        BUZ_ALERT   = 3'd4
    } buzzer_t;

    // result payload, last member in the lowest bits
    typedef struct packed {
        buzzer_t           buzzer_event;
        mode_t             mode_now;
        logic [SEQ_W-1:0]  ack_sequence;
        reason_t           ack_reason;
        status_t           ack_status;
        cmd_t              ack_command;
        logic [SPEED_W-1:0] motor_speed;
        action_t           motor_action;
    } result_t;

    typedef struct packed {
        logic mode_event_valid;
        logic ack_valid;
        logic motor_valid;
    } result_flags_t;

    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = ((($bits(result_t) + 7) / 8) * 8);

    function automatic cmd_t cmd_code(input logic [7:0] c);
        cmd_t code;
        case (c)
            "F", "f": code = CMD_F;
            "M", "m": code = CMD_M;
            "W", "w": code = CMD_W;
            "S", "s": code = CMD_S;
            "A", "a": code = CMD_A;
            "D", "d": code = CMD_D;
            "Q", "q": code = CMD_Q;
            "E", "e": code = CMD_E;
            "P", "p": code = CMD_P;
            "+":      code = CMD_PLUS;
            "-":      code = CMD_MINUS;
            default:  code = CMD_UNKNOWN;
        endcase
        return code;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    // '0' gives full speed, '1'..'9' give ten times the digit
    function automatic logic [SPEED_W-1:0] digit_speed(input logic [7:0] c);
        logic [SPEED_W-1:0] v;
        v = {3'b000, c[3:0]};
        return (v == '0) ? SPEED_MAX : v * SPEED_STEP;
    endfunction

endpackage

@@ rtl/drive_command_interlock.sv @@
// Drive command interlock top level.
// Decodes command bytes and distance samples into motor, ack and buzzer items.
// Depends on dci_pkg.
//
// Use:
//   s_axis carries input items: tuser flags the kind (control tick or distance
//   sample, and whether a tick carries a command byte), tdata holds the byte
//   and the sample. Each accepted input item yields exactly one result item on
//   m_axis: tuser flags which parts (motor, ack, mode event) are present,
//   tdata carries the payload.
//   The cfg port writes the stop distance (index 0) and the heartbeat timeout
//   (index 1); write only while no item is in flight.
// Timing:
//   The result is registered and is valid in the cycle after the input is accepted. One
//   item is taken each cycle while m_axis does not stall; the whole decode sits between
//   the state registers and the result register.
// Reset:
//   Manual mode, stopped, speed 50, last distance 400, heartbeat age at the
//   reset timeout, sequence 0, stop distance 20, timeout 20. No result pending.
// Stall:
//   A result holds on m_axis until taken; s_axis_tready stays high while the
//   result register is empty or is being taken in the same cycle.
module drive_command_interlock
    import dci_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // command_byte[7:0], distance_cm[16:8], zero fill
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // operation[0], byte_valid[1]
    input  logic [1:0]            s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // motor_action[2:0], motor_speed[9:3], ack_command[13:10], ack_status[15:14],
    // ack_reason[17:16], ack_sequence[33:18], mode_now[34], buzzer_event[37:35]
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // motor_valid[0], ack_valid[1], mode_event_valid[2]
    output logic [2:0]            m_axis_tuser,
    input  logic                  cfg_we,
    input  logic                  cfg_index,
    input  logic [CFG_W-1:0]      cfg_data
);

    logic [DIST_W-1:0]  stop_dist_reg;
    logic [AGE_W-1:0]   timeout_reg;

    mode_t              mode_reg, mode_next;
    action_t            dir_reg, dir_next;
    logic [SPEED_W-1:0] speed_reg, speed_next;
    logic [DIST_W-1:0]  dist_reg, dist_next;
    logic [AGE_W-1:0]   age_reg, age_next;
    logic [SEQ_W-1:0]   count_reg, count_next;

    logic               out_valid_reg;
    result_t            result_reg, result_next;
    result_flags_t      flags_reg, flags_next;

    op_t                in_op;
    logic               in_byte_valid;
    logic [7:0]         in_byte;
    logic [DIST_W-1:0]  in_dist;
    logic [DIST_W-1:0]  sample_cm;
    logic [AGE_W-1:0]   age_step;
    cmd_t               code;
    logic               fwd_blocked;
    logic               speed_cmd;
    logic               ended;
    logic               accept;

    assign in_op         = op_t'(s_axis_tuser[0]);
    assign in_byte_valid = s_axis_tuser[1];
    assign in_byte       = s_axis_tdata[7:0];
    assign in_dist       = s_axis_tdata[16:8];

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign code        = cmd_code(in_byte);
    assign fwd_blocked = (dist_reg == '0) || (dist_reg <= stop_dist_reg);
    assign sample_cm   = (in_dist == '0) ? NO_ECHO_CM : in_dist;

    always_comb
    begin
        mode_next   = mode_reg;
        dir_next    = dir_reg;
        speed_next  = speed_reg;
        dist_next   = dist_reg;
        age_next    = age_reg;
        count_next  = count_reg;
        result_next = '0;
        flags_next  = '0;
        speed_cmd   = 1'b0;
        ended       = 1'b0;
        age_step    = age_reg;

        if (in_op == OP_SAMPLE)
        begin
            dist_next = sample_cm;
            if (mode_reg == MODE_AUTO && sample_cm <= stop_dist_reg)
            begin
                flags_next.motor_valid   = 1'b1;
                result_next.motor_action = ACT_STOP;
                dir_next                 = ACT_STOP;
            end
        end
        else
        begin
            if (in_byte_valid)
            begin
                age_next                 = '0;
                count_next               = count_reg + 1'b1;
                flags_next.ack_valid     = 1'b1;
                result_next.ack_sequence = count_next;
                result_next.ack_command  = code;
                result_next.ack_status   = ST_EXECUTED;
                result_next.ack_reason   = RSN_NONE;
                if (is_digit(in_byte))
                begin
                    speed_next = digit_speed(in_byte);
                    speed_cmd  = 1'b1;
                end
                else
                begin
                    unique case (code) inside
                        CMD_F, CMD_M:
                        begin
                            mode_next                   = (code == CMD_F) ? MODE_AUTO
                                                                          : MODE_MANUAL;
                            flags_next.motor_valid      = 1'b1;
                            result_next.motor_action    = ACT_STOP;
                            dir_next                    = ACT_STOP;
                            result_next.buzzer_event    = (code == CMD_F) ? BUZ_STARTUP
                                                                          : BUZ_MODE;
                            flags_next.mode_event_valid = 1'b1;
                            ended                       = 1'b1;
                        end
                        CMD_W:
                        begin
                            flags_next.motor_valid = 1'b1;
                            if (fwd_blocked)
                            begin
                                result_next.motor_action = ACT_STOP;
                                dir_next                 = ACT_STOP;
                                result_next.buzzer_event = BUZ_ALERT;
                                result_next.ack_status   = ST_BLOCKED;
                                result_next.ack_reason   = RSN_OBSTACLE;
                            end
                            else
                            begin
                                result_next.motor_action = ACT_FWD;
                                result_next.motor_speed  = speed_reg;
                                dir_next                 = ACT_FWD;
                            end
                        end
                        CMD_S:
                        begin
                            flags_next.motor_valid   = 1'b1;
                            result_next.motor_action = ACT_BACK;
                            result_next.motor_speed  = speed_reg;
                            dir_next                 = ACT_BACK;
                            result_next.buzzer_event = BUZ_REVERSE;
                        end
                        CMD_A, CMD_Q:
                        begin
                            flags_next.motor_valid   = 1'b1;
                            result_next.motor_action = ACT_LEFT;
                            result_next.motor_speed  = speed_reg;
                            dir_next                 = ACT_LEFT;
                        end
                        CMD_D, CMD_E:
                        begin
                            flags_next.motor_valid   = 1'b1;
                            result_next.motor_action = ACT_RIGHT;
                            result_next.motor_speed  = speed_reg;
                            dir_next                 = ACT_RIGHT;
                        end
                        CMD_P:
                        begin
                            flags_next.motor_valid   = 1'b1;
                            result_next.motor_action = ACT_STOP;
                            dir_next                 = ACT_STOP;
                        end
                        CMD_PLUS:
                        begin
                            if (speed_reg <= SPEED_INC_LIMIT)
                            begin
                                speed_next = speed_reg + SPEED_STEP;
                            end
                            speed_cmd = 1'b1;
                        end
                        CMD_MINUS:
                        begin
                            if (speed_reg >= SPEED_STEP)
                            begin
                                speed_next = speed_reg - SPEED_STEP;
                            end
                            speed_cmd = 1'b1;
                        end
                        default:
                        begin
                            result_next.ack_command = CMD_UNKNOWN;
                            result_next.ack_status  = ST_REJECTED;
                            result_next.ack_reason  = RSN_UNKNOWN;
                        end
                    endcase
                end

                // reissue the running drive at the new speed, or stop it if forward is blocked
                if (speed_cmd && dir_reg != ACT_STOP)
                begin
                    flags_next.motor_valid = 1'b1;
                    if (dir_reg == ACT_FWD && fwd_blocked)
                    begin
                        result_next.motor_action = ACT_STOP;
                        dir_next                 = ACT_STOP;
                        result_next.buzzer_event = BUZ_ALERT;
                        result_next.ack_status   = ST_BLOCKED;
                        result_next.ack_reason   = RSN_OBSTACLE;
                        ended                    = 1'b1;
                    end
                    else
                    begin
                        result_next.motor_action = dir_reg;
                        result_next.motor_speed  = speed_next;
                    end
                end
            end

            // heartbeat
            age_step = age_next;
            if (!ended && mode_next == MODE_AUTO)
            begin
                if (age_next < timeout_reg)
                begin
                    age_step = age_next + 1'b1;
                end
                age_next = age_step;
                if (age_step >= timeout_reg)
                begin
                    flags_next.motor_valid   = 1'b1;
                    result_next.motor_action = ACT_STOP;
                    result_next.motor_speed  = '0;
                    dir_next                 = ACT_STOP;
                end
            end
        end

        result_next.mode_now = mode_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stop_dist_reg <= STOP_DIST_RESET;
            timeout_reg   <= TIMEOUT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (reg_index_t'(cfg_index))
                REG_STOP_DIST: stop_dist_reg <= cfg_data[DIST_W-1:0];
                REG_TIMEOUT:   timeout_reg   <= cfg_data[AGE_W-1:0];
                default:       stop_dist_reg <= stop_dist_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_MANUAL;
            dir_reg   <= ACT_STOP;
            speed_reg <= SPEED_RESET;
            dist_reg  <= NO_ECHO_CM;
            age_reg   <= TIMEOUT_RESET;
            count_reg <= '0;
        end
        else if (accept)
        begin
            mode_reg  <= mode_next;
            dir_reg   <= dir_next;
            speed_reg <= speed_next;
            dist_reg  <= dist_next;
            age_reg   <= age_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_reg <= result_next;
            flags_reg  <= flags_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_DATA_W - $bits(result_t)){1'b0}}, result_reg};
    assign m_axis_tuser  = flags_reg;

endmodule

@@ rtl/dci_checker.sv @@
// Port-level checker for the drive command interlock, bound to the top level.
// Depends on dci_pkg and drive_command_interlock.
module dci_checker
    import dci_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata,
    input logic [2:0]            m_axis_tuser
);

    result_t       res;
    result_flags_t flg;

    assign res = result_t'(m_axis_tdata[$bits(result_t)-1:0]);
    assign flg = result_flags_t'(m_axis_tuser);

    // a result appears only after an input item was taken
    a_result_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready))
        else $error("result without accepted input item");

    // a stalled result holds
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

    // a stop command carries zero speed
    a_stop_zero_speed: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && flg.motor_valid && res.motor_action == ACT_STOP
            |-> res.motor_speed == '0)
        else $error("stop with nonzero speed");

    // a mode change stops the motor, acknowledges and sounds the buzzer
    a_mode_event: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && flg.mode_event_valid |->
            flg.motor_valid && flg.ack_valid && res.motor_action == ACT_STOP &&
            (res.buzzer_event == BUZ_STARTUP || res.buzzer_event == BUZ_MODE))
        else $error("mode event without stop and buzzer");

    // ack fields stay zero when no ack is given
    a_ack_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !flg.ack_valid |->
            res.ack_command == CMD_F && res.ack_status == ST_EXECUTED &&
            res.ack_reason == RSN_NONE && res.ack_sequence == '0)
        else $error("ack fields set without ack");

endmodule

bind drive_command_interlock dci_checker u_dci_checker (.*);
